@@ rtl/core/fpr_pkg.sv @@
package fpr_pkg;

  localparam int unsigned MaxFramesDef = 16;
  localparam int unsigned PageBitsDef  = 16;

  localparam int unsigned PageNumW = 16;
  localparam int unsigned FiuW     = 5;
  localparam int unsigned CntW     = 32;

  localparam logic [FiuW-1:0] FiuRst = 5'd16;

  // control broadcast to every cell of the frame row
  typedef struct packed {
    logic clear;  // drop every resident page
    logic shift;  // load a new page at the head, age the rest
  } cell_ctrl_t;

endpackage

@@ rtl/core/fpr_cell.sv @@
module fpr_cell import fpr_pkg::*; #(
  parameter int unsigned PgW = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  cell_ctrl_t     ctrl_i,
  input  logic           in_range_i,
  input  logic [PgW-1:0] prev_page_i,
  input  logic           prev_valid_i,
  input  logic [PgW-1:0] cmp_page_i,
  output logic [PgW-1:0] page_o,
  output logic           valid_o,
  output logic           match_o
);

  logic [PgW-1:0] page_q;
  logic           valid_q, valid_d;

  always_comb begin
    valid_d = valid_q;
    if (ctrl_i.clear) begin
      valid_d = 1'b0;
    end else if (ctrl_i.shift) begin
      // cells past the active frame count never hold a page
      valid_d = prev_valid_i & in_range_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift) begin
      page_q <= prev_page_i;
    end
  end

  assign page_o  = page_q;
  assign valid_o = valid_q;
  assign match_o = valid_q && (page_q == cmp_page_i);

endmodule

@@ rtl/core/fpr_sat_cnt.sv @@
module fpr_sat_cnt import fpr_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            inc_i,
  output logic [CntW-1:0] count_o
);

  logic [CntW-1:0] count_q, count_d;

  always_comb begin
    count_d = count_q;
    // hold at all ones
    if (inc_i && (count_q != '1)) begin
      count_d = count_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  assign count_o = count_q;

endmodule

@@ rtl/core/fifo_page_replacement.sv @@
// An accepted reference has its result registered on the outputs in the next cycle, with
// done_o high for a single cycle; the receiver cannot stall it.
// Throughput: one reference per cycle, busy stays low; a row of frame cells compares
// all frames in parallel and shifts a missed page in at the head in that same cycle.
// Reset: all frames empty, both counters zero, frames_in_use at 16.
// A frames_in_use write empties all frames and keeps the counters.
module fifo_page_replacement import fpr_pkg::*; #(
  parameter int unsigned MAX_FRAMES = MaxFramesDef,
  parameter int unsigned PAGE_BITS  = PageBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic [PageNumW-1:0] page_number_i,
  input  logic                last_reference_i,
  output logic                done_o,
  output logic                hit_o,
  output logic                evicted_valid_o,
  output logic [PageNumW-1:0] evicted_page_o,
  output logic [CntW-1:0]     hits_so_far_o,
  output logic [CntW-1:0]     faults_so_far_o,
  output logic                last_result_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [FiuW-1:0]     cfg_data_i
);

  localparam int unsigned PgW     = (PAGE_BITS < PageNumW) ? PAGE_BITS : PageNumW;
  localparam int unsigned FrmCntW = $clog2(MAX_FRAMES + 1);

  logic [FiuW-1:0]    fiu_q;
  logic [FrmCntW-1:0] n_active;
  logic               accept, cfg_wr, any_hit, miss;
  logic [PgW-1:0]     ref_page;
  cell_ctrl_t         ctrl;

  logic [PgW-1:0]        cell_page  [MAX_FRAMES];
  logic [MAX_FRAMES-1:0] cell_valid;
  logic [MAX_FRAMES-1:0] cell_match;

  logic           ev_valid;
  logic [PgW-1:0] ev_page;

  logic                done_q, hit_q, ev_valid_q, last_q;
  logic [PageNumW-1:0] ev_page_q;
  logic [CntW-1:0]     hit_cnt, fault_cnt;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start && !busy;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;
  assign ref_page    = page_number_i[PgW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fiu_q <= FiuRst;
    end else if (cfg_wr) begin
      fiu_q <= cfg_data_i;
    end
  end

  // clamp the register to 1..MAX_FRAMES
  always_comb begin
    if (fiu_q == '0) begin
      n_active = FrmCntW'(1);
    end else if (32'(fiu_q) > 32'(MAX_FRAMES)) begin
      n_active = FrmCntW'(MAX_FRAMES);
    end else begin
      n_active = FrmCntW'(fiu_q);
    end
  end

  assign any_hit    = |cell_match;
  assign miss       = accept && !any_hit;
  assign ctrl.clear = cfg_wr;
  assign ctrl.shift = miss;

  for (genvar gi = 0; gi < MAX_FRAMES; gi++) begin : g_cell
    logic [PgW-1:0] prev_page;
    logic           prev_valid;
    logic           in_range;

    if (gi == 0) begin : g_head
      assign prev_page  = ref_page;
      assign prev_valid = 1'b1;
    end else begin : g_body
      assign prev_page  = cell_page[gi-1];
      assign prev_valid = cell_valid[gi-1];
    end

    assign in_range = (32'(gi) < 32'(n_active));

    fpr_cell #(
      .PgW(PgW)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .in_range_i  (in_range),
      .prev_page_i (prev_page),
      .prev_valid_i(prev_valid),
      .cmp_page_i  (ref_page),
      .page_o      (cell_page[gi]),
      .valid_o     (cell_valid[gi]),
      .match_o     (cell_match[gi])
    );
  end

  // the oldest page sits in the last active cell
  always_comb begin
    ev_valid = 1'b0;
    ev_page  = '0;
    for (int i = 0; i < MAX_FRAMES; i++) begin
      if (32'(i + 1) == 32'(n_active)) begin
        ev_valid = cell_valid[i];
        ev_page  = cell_page[i];
      end
    end
  end

  fpr_sat_cnt u_hit_cnt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .inc_i  (accept && any_hit),
    .count_o(hit_cnt)
  );

  fpr_sat_cnt u_fault_cnt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .inc_i  (miss),
    .count_o(fault_cnt)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      hit_q      <= any_hit;
      ev_valid_q <= !any_hit && ev_valid;
      ev_page_q  <= (!any_hit && ev_valid) ? PageNumW'(ev_page) : '0;
      last_q     <= last_reference_i;
    end
  end

  assign done_o          = done_q;
  assign hit_o           = hit_q;
  assign evicted_valid_o = ev_valid_q;
  assign evicted_page_o  = ev_page_q;
  assign hits_so_far_o   = hit_cnt;
  assign faults_so_far_o = fault_cnt;
  assign last_result_o   = last_q;

endmodule
